[design/mcop_pkg.sv]
package mcop_pkg;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ARM      = 2'd1;
    localparam logic [1:0] OP_STOP     = 2'd2;
    localparam logic [1:0] OP_STOP_ALL = 2'd3;

    localparam int OPCODE_BITS  = 2;
    localparam int CHANNEL_BITS = 3;
    localparam int LENGTH_BITS  = 16;
    localparam int IN_BITS      = CHANNEL_BITS + LENGTH_BITS;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic en;
        logic tick;
        logic load;
        logic clear;
    } chan_ctl_t;

endpackage

[design/mcop_channel.sv]
module mcop_channel #(
    parameter int COUNT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mcop_pkg::chan_ctl_t     ctl,
    input  logic [COUNT_BITS-1:0]   limit_in,
    output logic                    run_next,
    output logic                    pin_next
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] limit_reg;
    logic [COUNT_BITS-1:0] limit_next;
    logic                  run_reg;

    always_comb
    begin
        count_next = count_reg;
        limit_next = limit_reg;
        run_next   = run_reg;
        if (ctl.en)
        begin
            if (ctl.clear)
            begin
                run_next   = 1'b0;
                count_next = '0;
            end
            else if (ctl.load)
            begin
                limit_next = limit_in;
                count_next = '0;
                run_next   = 1'b1;
            end
            else if (ctl.tick && run_reg)
            begin
                if (count_reg == limit_reg)
                begin
                    count_next = '0;
                    run_next   = 1'b0;
                end
                else
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
        end
        pin_next = run_next && (count_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= '0;
            run_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            limit_reg <= limit_next;
            run_reg   <= run_next;
        end
    end

endmodule

[design/multi_channel_one_shot_pulser_top.sv]
// channel  direction  tdata fields (low bit up)                      tuser
// s_axis   in         channel[2:0], pulse_length[18:3], zero pad     opcode[1:0]
// m_axis   out        pin_mask, active_mask, any_high, rejected, pad  -
//
// one transfer in and one result out per cycle, sustained while m_tready stays high
// result path runs through the input register, then channel update and result register
// all channels update in parallel in one pass of counter logic
// reset stops every channel and clears counters and limits
// an output stall holds the result; the input register keeps taking transfers
// until it is full behind the held result
module multi_channel_one_shot_pulser_top #(
    parameter int CHANNELS   = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [mcop_pkg::IN_TDATA_W-1:0]            s_tdata,  // channel, pulse_length
    input  logic [mcop_pkg::OPCODE_BITS-1:0]           s_tuser,  // opcode
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [(((2*CHANNELS+2)+7)/8)*8-1:0]        m_tdata   // pin_mask, active_mask,
                                                                 // any_high, rejected
);

    localparam int OUT_BITS = 2 * CHANNELS + 2;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic                                  in_valid_reg;
    logic [mcop_pkg::OPCODE_BITS-1:0]      op_reg;
    logic [mcop_pkg::CHANNEL_BITS-1:0]     ch_reg;
    logic [mcop_pkg::LENGTH_BITS-1:0]      len_reg;
    logic                                  out_valid_reg;
    logic [OUT_W-1:0]                      out_data_reg;

    logic                                  adv;
    logic [31:0]                           len_wide;
    logic [COUNT_BITS-1:0]                 len_cut;
    logic                                  ch_bad;
    logic                                  is_arm;
    logic                                  is_stop;
    logic                                  bad;
    logic [CHANNELS-1:0]                   run_next;
    logic [CHANNELS-1:0]                   pin_next;
    logic [OUT_W-1:0]                      out_data_next;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    assign len_wide = {16'd0, len_reg};
    assign len_cut  = len_wide[COUNT_BITS-1:0];
    assign ch_bad   = {1'b0, ch_reg} >= 4'(CHANNELS);
    assign is_arm   = op_reg == mcop_pkg::OP_ARM;
    assign is_stop  = op_reg == mcop_pkg::OP_STOP;
    assign bad      = (is_arm && (ch_bad || len_cut == '0)) || (is_stop && ch_bad);

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        mcop_pkg::chan_ctl_t ctl;
        logic                hit;

        assign hit       = ch_reg == 3'(c);
        assign ctl.en    = adv;
        assign ctl.tick  = op_reg == mcop_pkg::OP_TICK;
        assign ctl.load  = is_arm && !bad && hit;
        assign ctl.clear = (is_stop && !bad && hit) || (op_reg == mcop_pkg::OP_STOP_ALL);

        mcop_channel #(
            .COUNT_BITS (COUNT_BITS)
        ) u_chan (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .limit_in (len_cut),
            .run_next (run_next[c]),
            .pin_next (pin_next[c])
        );
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[OUT_BITS-1:0] = {bad, |pin_next, run_next, pin_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tuser;
            ch_reg  <= s_tdata[mcop_pkg::CHANNEL_BITS-1:0];
            len_reg <= s_tdata[mcop_pkg::IN_BITS-1:mcop_pkg::CHANNEL_BITS];
        end
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[design/mcop_checker.sv]
module mcop_checker #(
    parameter int CHANNELS = 6
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [(((2*CHANNELS+2)+7)/8)*8-1:0]    m_tdata
);

    logic [CHANNELS-1:0] pins;
    logic [CHANNELS-1:0] act;
    logic                any_high;

    assign pins     = m_tdata[CHANNELS-1:0];
    assign act      = m_tdata[2*CHANNELS-1:CHANNELS];
    assign any_high = m_tdata[2*CHANNELS];

    a_any_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (any_high == (|pins)))
        else $error("any_high does not match pin levels");

    a_pin_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((pins & ~act) == '0))
        else $error("pin high on a stopped channel");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind multi_channel_one_shot_pulser_top mcop_checker #(
    .CHANNELS (CHANNELS)
) u_mcop_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
